FILE: rtl/stereo_crossfeed_delay_top_defines.svh
// assertion macros used by the checker file
`ifndef STEREO_CROSSFEED_DELAY_TOP_DEFINES_SVH
`define STEREO_CROSSFEED_DELAY_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked from the cycle after the antecedent
`define SCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/scd_pkg.sv
package scd_pkg;

	// default sizes
	localparam int DEPTH_DEF       = 65536;
	localparam int SAMPLE_BITS_DEF = 16;

	// crossfeed gains, q0.15
	localparam logic signed [16:0] GAIN_OWN   = 17'sd27853;
	localparam logic signed [16:0] GAIN_OTHER = 17'sd4915;

	// register limits
	localparam logic [14:0] FB_MAX   = 15'd31130;
	localparam logic [15:0] MIX_FULL = 16'd32768;

	// register reset values
	localparam logic        ENABLE_RST   = 1'b1;
	localparam logic [15:0] DELAY_RST    = 16'd8640;
	localparam logic [15:0] MIX_RST      = 16'd8192;
	localparam logic [14:0] FEEDBACK_RST = 15'd9830;

	// configuration port
	localparam int PADDR_BITS = 4;
	localparam int PDATA_BITS = 32;

	typedef enum logic [1:0] {
		REG_ENABLE   = 2'd0,
		REG_DELAY    = 2'd1,
		REG_MIX      = 2'd2,
		REG_FEEDBACK = 2'd3
	} scd_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CROSS,
		ST_FEED,
		ST_BLEND
	} scd_state_t;

	// per-transaction strobes from the sequencer to both lanes
	typedef struct packed {
		logic rd_en;
		logic cross_en;
		logic feed_en;
		logic wr_en;
	} scd_ctrl_t;

endpackage

FILE: rtl/scd_lane.sv
module scd_lane
	import scd_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int AW         = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  scd_ctrl_t                     ctrl,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [AW-1:0]                 wr_addr,
	input  logic                          rd_hit,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [SAMPLE_BITS-1:0] other_dly,
	input  logic signed [SAMPLE_BITS+16:0] dry,
	input  logic [14:0]                   fb,
	input  logic [15:0]                   mix,
	output logic signed [SAMPLE_BITS-1:0] own_dly,
	output logic signed [SAMPLE_BITS-1:0] wet_out
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = SAMPLE_BITS + 17;

	// clamp a two-bit-wider value to the sample range
	function automatic logic [SB-1:0] sat_sample(input logic [SB+1:0] v);
		logic top_same;
		top_same = (v[SB+1:SB-1] == 3'b000) || (v[SB+1:SB-1] == 3'b111);
		if (top_same)
			return v[SB-1:0];
		else if (v[SB+1])
			return {1'b1, {(SB-1){1'b0}}};
		else
			return {1'b0, {(SB-1){1'b1}}};
	endfunction

	logic [SB-1:0]        mem [DEPTH];
	logic [SB-1:0]        rd_data_s1;
	logic signed [SB:0]   cross_s2;
	logic [SB-1:0]        line_s3;

	logic signed [PW-1:0] cross_sum;
	logic signed [PW-1:0] cross_adj;
	logic signed [PW-1:0] fb_prod;
	logic signed [PW-1:0] fb_adj;
	logic signed [SB:0]   fb_term;
	logic signed [SB+1:0] line_sum;
	logic signed [PW-1:0] wet_prod;
	logic signed [PW-1:0] blend_sum;
	logic signed [PW-1:0] blend_adj;

	// delay line: read at acceptance, written back at the end of the transaction
	always_ff @(posedge clk) begin
		if (ctrl.wr_en)
			mem[wr_addr] <= line_s3;
		if (ctrl.rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	// entries not yet written since reset read as silence
	assign own_dly = rd_hit ? signed'(rd_data_s1) : '0;

	// crossfeed mix, truncated toward zero
	always_comb begin
		cross_sum = PW'(own_dly) * PW'(GAIN_OWN) + PW'(other_dly) * PW'(GAIN_OTHER);
		cross_adj = cross_sum + PW'({15{cross_sum[PW-1]}});
	end

	always_ff @(posedge clk) begin
		if (ctrl.cross_en)
			cross_s2 <= signed'(cross_adj[SB+15:15]);
	end

	// feedback scaling and input sum
	always_comb begin
		fb_prod  = PW'(cross_s2) * PW'(signed'({1'b0, fb}));
		fb_adj   = fb_prod + PW'({15{fb_prod[PW-1]}});
		fb_term  = signed'(fb_adj[SB+15:15]);
		line_sum = (SB+2)'(x) + (SB+2)'(fb_term);
	end

	always_ff @(posedge clk) begin
		if (ctrl.feed_en)
			line_s3 <= sat_sample(line_sum);
	end

	// wet share added to the shared dry product
	always_comb begin
		wet_prod  = PW'(own_dly) * PW'(signed'({1'b0, mix}));
		blend_sum = wet_prod + dry;
		blend_adj = blend_sum + PW'({15{blend_sum[PW-1]}});
		wet_out   = signed'(sat_sample(blend_adj[SB+16:15]));
	end

endmodule

FILE: rtl/stereo_crossfeed_delay_top.sv
// channel  | handshake                      | payload
// input    | in_valid / in_stall            | sample_in
// output   | out_valid / out_stall          | left_out, right_out
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// an accepted sample shows its stereo pair on out_valid after the crossfeed, feedback and blend steps;
// a transaction steps through read, crossfeed, feedback and blend around the line memories
// reset restores the register defaults; unwritten line entries read as zero until the
// write pointer first wraps, so no clearing pass runs after reset
// a result waiting on out_stall holds the blend step; no new sample is taken meanwhile
module stereo_crossfeed_delay_top
	import scd_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_BITS-1:0]         paddr,
	input  logic [PDATA_BITS-1:0]         pwdata,
	output logic [PDATA_BITS-1:0]         prdata,
	output logic                          pready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW > 16) ? AW : 16;
	localparam int SB = SAMPLE_BITS;
	localparam int PW = SAMPLE_BITS + 17;

	scd_state_t state_q, state_nxt;
	scd_ctrl_t  ctrl;

	logic        delay_enable_q;
	logic [15:0] delay_samples_q;
	logic [15:0] wet_mix_q;
	logic [14:0] feedback_gain_q;

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic          out_valid_q;
	logic [SB-1:0] left_q;
	logic [SB-1:0] right_q;

	logic signed [SB-1:0] x_s1;
	logic                 hit_s1;
	logic                 bypass_s1;
	logic signed [PW-1:0] dry_s2;

	logic          cfg_wr;
	scd_reg_t      cfg_reg;
	logic [15:0]   mix_wr;
	logic [14:0]   fb_wr;
	logic [CW-1:0] dly_ext;
	logic [AW-1:0] dly;
	logic [AW:0]   rd_wrap;
	logic [AW-1:0] rd_addr;
	logic          rd_hit;
	logic          wp_last;
	logic          out_free;
	logic          out_load;
	logic [16:0]   dry_gain;

	logic signed [SB-1:0] left_dly;
	logic signed [SB-1:0] right_dly;
	logic signed [SB-1:0] left_wet;
	logic signed [SB-1:0] right_wet;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_reg = scd_reg_t'(paddr[3:2]);
	assign mix_wr  = (pwdata[15:0] > MIX_FULL) ? MIX_FULL : pwdata[15:0];
	assign fb_wr   = (pwdata[14:0] > FB_MAX) ? FB_MAX : pwdata[14:0];

	always_comb begin
		unique case (cfg_reg)
			REG_ENABLE:   prdata = PDATA_BITS'(delay_enable_q);
			REG_DELAY:    prdata = PDATA_BITS'(delay_samples_q);
			REG_MIX:      prdata = PDATA_BITS'(wet_mix_q);
			REG_FEEDBACK: prdata = PDATA_BITS'(feedback_gain_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_enable_q  <= ENABLE_RST;
			delay_samples_q <= DELAY_RST;
			wet_mix_q       <= MIX_RST;
			feedback_gain_q <= FEEDBACK_RST;
		end else if (cfg_wr) begin
			unique case (cfg_reg)
				REG_ENABLE:   delay_enable_q  <= pwdata[0];
				REG_DELAY:    delay_samples_q <= pwdata[15:0];
				REG_MIX:      wet_mix_q       <= mix_wr;
				REG_FEEDBACK: feedback_gain_q <= fb_wr;
				default:      ;
			endcase
		end
	end

	// read address: delay clipped to the line length, wrapped behind the write pointer
	always_comb begin
		dly_ext = CW'(delay_samples_q);
		dly     = (dly_ext > CW'(DEPTH - 1)) ? AW'(DEPTH - 1) : AW'(dly_ext);
		rd_wrap = (AW+1)'(wp_q) + (AW+1)'(DEPTH) - (AW+1)'(dly);
		rd_addr = (wp_q >= dly) ? (wp_q - dly) : rd_wrap[AW-1:0];
		rd_hit  = wrapped_q || ((dly != '0) && (wp_q >= dly));
		wp_last = (wp_q == AW'(DEPTH - 1));
	end

	assign out_free = !out_valid_q || !out_stall;

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_CROSS;
			ST_CROSS: state_nxt = ST_FEED;
			ST_FEED:  state_nxt = ST_BLEND;
			ST_BLEND: if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl     = '0;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				ctrl.rd_en = in_valid;
			end
			ST_CROSS: ctrl.cross_en = 1'b1;
			ST_FEED:  ctrl.feed_en = 1'b1;
			ST_BLEND: begin
				out_load   = out_free;
				ctrl.wr_en = out_free && !bypass_s1;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.wr_en) begin
				wp_q      <= wp_last ? '0 : wp_q + AW'(1);
				wrapped_q <= wrapped_q || wp_last;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign dry_gain = 17'(MIX_FULL) - {1'b0, wet_mix_q};

	// transaction payload
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			x_s1      <= sample_in;
			hit_s1    <= rd_hit;
			bypass_s1 <= !delay_enable_q;
		end
		if (ctrl.cross_en)
			dry_s2 <= PW'(x_s1) * PW'(signed'(dry_gain));
		if (out_load) begin
			left_q  <= bypass_s1 ? x_s1 : left_wet;
			right_q <= bypass_s1 ? x_s1 : right_wet;
		end
	end

	scd_lane #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_left (
		.clk       (clk),
		.ctrl      (ctrl),
		.rd_addr   (rd_addr),
		.wr_addr   (wp_q),
		.rd_hit    (hit_s1),
		.x         (x_s1),
		.other_dly (right_dly),
		.dry       (dry_s2),
		.fb        (feedback_gain_q),
		.mix       (wet_mix_q),
		.own_dly   (left_dly),
		.wet_out   (left_wet)
	);

	scd_lane #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_right (
		.clk       (clk),
		.ctrl      (ctrl),
		.rd_addr   (rd_addr),
		.wr_addr   (wp_q),
		.rd_hit    (hit_s1),
		.x         (x_s1),
		.other_dly (left_dly),
		.dry       (dry_s2),
		.fb        (feedback_gain_q),
		.mix       (wet_mix_q),
		.own_dly   (right_dly),
		.wet_out   (right_wet)
	);

	assign out_valid = out_valid_q;
	assign left_out  = signed'(left_q);
	assign right_out = signed'(right_q);

endmodule

FILE: rtl/scd_checker.sv
`include "stereo_crossfeed_delay_top_defines.svh"

module scd_checker
	import scd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [SAMPLE_BITS-1:0] left_out,
	input logic [SAMPLE_BITS-1:0] right_out
);

	// one transaction in flight: busy for the three steps after acceptance
	`SCD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall ##1 in_stall ##1 in_stall, "input taken while a transaction is in flight")

	// a new result only appears at the end of a busy stretch
	`SCD_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared without a transaction in flight")

	// input side frees up once the output register is loaded
	`SCD_ASSERT_NOW(a_free_after_load, clk, arst_n, $rose(out_valid), !in_stall, "input side still busy after result load")

	// stalled result holds
	`SCD_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(left_out) && $stable(right_out), "stalled result changed")

endmodule

bind stereo_crossfeed_delay_top scd_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_scd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.left_out  (left_out),
	.right_out (right_out)
);

FILE: dv/tb_stereo_crossfeed_delay_top.sv
`timescale 1ns / 1ps
module tb_stereo_crossfeed_delay_top;
	import scd_pkg::*;

	localparam int LINE_DEPTH  = DEPTH_DEF;
	localparam int SW          = SAMPLE_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CALM_FIRST  = 1500;
	localparam int CALM_LAST   = 2700;
	localparam int SAMPLE_GOAL = 650;

	typedef logic signed [SW-1:0] sample_t;
	typedef struct packed {
		sample_t left;
		sample_t right;
	} stereo_pair_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	sample_t               sample_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	sample_t               left_out;
	sample_t               right_out;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [PADDR_BITS-1:0] paddr     = '0;
	logic [PDATA_BITS-1:0] pwdata    = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	// echo line mirror and register copy
	sample_t     left_echo [LINE_DEPTH];
	sample_t     right_echo [LINE_DEPTH];
	int unsigned echo_wp;
	logic        echo_on;
	logic [15:0] echo_delay;
	logic [15:0] echo_mix;
	logic [14:0] echo_fb;

	sample_t      sample_q [$];
	stereo_pair_t pair_q [$];
	int unsigned  cycle_cnt = 0;
	int           fail_cnt  = 0;
	logic         calm;

	// window where neither side idles
	assign calm = (cycle_cnt >= CALM_FIRST) && (cycle_cnt < CALM_LAST);

	always #5 clk = ~clk;

	stereo_crossfeed_delay_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	function automatic sample_t clamp_sample(longint v);
		longint hi = (longint'(1) <<< (SW - 1)) - 1;
		longint lo = -hi - 1;
		if (v > hi)
			return sample_t'(hi);
		if (v < lo)
			return sample_t'(lo);
		return sample_t'(v);
	endfunction

	// line input: x plus feedback times crossfed mix of own and other tap
	function automatic sample_t line_feed(sample_t x, longint own, longint other);
		longint xfeed;
		longint fb;
		fb = longint'(echo_fb);
		xfeed = (longint'(GAIN_OWN) * own + longint'(GAIN_OTHER) * other) / 32768;
		return clamp_sample(longint'(x) + (xfeed * fb) / 32768);
	endfunction

	// dry/wet blend
	function automatic sample_t dry_wet(sample_t x, longint wet);
		longint m;
		longint full;
		m = longint'(echo_mix);
		full = longint'(MIX_FULL);
		return clamp_sample((longint'(x) * (full - m) + wet * m) / 32768);
	endfunction

	// one sample through both echo lines
	function automatic stereo_pair_t echo_step(sample_t x);
		stereo_pair_t p;
		int unsigned  d;
		int unsigned  rd;
		longint       dl;
		longint       dr;
		if (!echo_on) begin
			p.left = x;
			p.right = x;
			return p;
		end
		d = (echo_delay > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : echo_delay;
		rd = (echo_wp + LINE_DEPTH - d) % LINE_DEPTH;
		dl = left_echo[rd];
		dr = right_echo[rd];
		left_echo[echo_wp] = line_feed(x, dl, dr);
		right_echo[echo_wp] = line_feed(x, dr, dl);
		echo_wp = (echo_wp + 1) % LINE_DEPTH;
		p.left = dry_wet(x, dl);
		p.right = dry_wet(x, dr);
		return p;
	endfunction

	function automatic void set_reg(scd_reg_t r, logic [PDATA_BITS-1:0] v);
		case (r)
			REG_ENABLE: begin
				echo_on = v[0];
			end
			REG_DELAY: begin
				echo_delay = v[15:0];
			end
			REG_MIX: begin
				echo_mix = (v[15:0] > MIX_FULL) ? MIX_FULL : v[15:0];
			end
			REG_FEEDBACK: begin
				echo_fb = (v[14:0] > FB_MAX) ? FB_MAX : v[14:0];
			end
		endcase
	endfunction

	function automatic sample_t pick_sample();
		int unsigned k = $urandom_range(99);
		if (k < 50)
			return sample_t'($urandom);
		if (k < 60)
			return sample_t'(32767 - int'($urandom_range(15)));
		if (k < 70)
			return sample_t'(-32768 + int'($urandom_range(15)));
		if (k < 85)
			return '0;
		return sample_t'(int'($urandom_range(511)) - 256);
	endfunction

	// append one sample to the pending input queue
	function automatic void stage_sample(sample_t s);
		sample_q = {sample_q, s};
	endfunction

	// apb write: setup then access
	task automatic write_reg(scd_reg_t r, logic [PDATA_BITS-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		set_reg(r, v);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || in_valid || pair_q.size() != 0);
	endtask

	task automatic queue_samples(int unsigned n);
		repeat (n)
			stage_sample(pick_sample());
	endtask

	// random register setting, mostly short delays so the echo builds up
	task automatic random_setup();
		logic [PDATA_BITS-1:0] noise;
		int unsigned           k;
		int unsigned           d;
		int unsigned           m;
		int unsigned           f;
		noise = $urandom;
		k = $urandom_range(99);
		write_reg(REG_ENABLE, {noise[31:1], k < 85});
		k = $urandom_range(99);
		if (k < 55)
			d = $urandom_range(1, 24);
		else if (k < 65)
			d = 0;
		else if (k < 75)
			d = 65535;
		else
			d = $urandom_range(0, 65535);
		noise = $urandom;
		write_reg(REG_DELAY, {noise[31:16], d[15:0]});
		k = $urandom_range(99);
		if (k < 15)
			m = 0;
		else if (k < 30)
			m = MIX_FULL;
		else if (k < 40)
			m = $urandom_range(32769, 65535);
		else
			m = $urandom_range(0, 32768);
		noise = $urandom;
		write_reg(REG_MIX, {noise[31:16], m[15:0]});
		k = $urandom_range(99);
		if (k < 20)
			f = FB_MAX;
		else if (k < 30)
			f = $urandom_range(31131, 32767);
		else if (k < 40)
			f = 0;
		else
			f = $urandom_range(0, 31130);
		noise = $urandom;
		write_reg(REG_FEEDBACK, {noise[31:15], f[14:0]});
	endtask

	// stimulus sequence
	initial begin
		int unsigned total;
		int unsigned n;
		foreach (left_echo[i]) begin
			left_echo[i] = '0;
			right_echo[i] = '0;
		end
		echo_wp    = 0;
		echo_on    = ENABLE_RST;
		echo_delay = DELAY_RST;
		echo_mix   = MIX_RST;
		echo_fb    = FEEDBACK_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, field extremes
		stage_sample(sample_t'(32767));
		stage_sample(sample_t'(-32768));
		stage_sample('0);
		stage_sample(sample_t'(-1));
		stage_sample(sample_t'(1));
		wait_drained();

		// one-sample delay, oversized feedback and full wet, line saturation
		write_reg(REG_DELAY, 32'h0000_0001);
		write_reg(REG_FEEDBACK, 32'hffff_ffff);
		write_reg(REG_MIX, 32'h0000_8000);
		repeat (4)
			stage_sample(sample_t'(32767));
		repeat (2)
			stage_sample(sample_t'(-32768));
		wait_drained();

		// zero delay reads the oldest entry, oversized mix
		write_reg(REG_DELAY, 32'hffff_0000);
		write_reg(REG_MIX, 32'h0000_ffff);
		stage_sample(sample_t'(12345));
		stage_sample(sample_t'(-32768));
		wait_drained();

		// fully dry
		write_reg(REG_DELAY, 32'h0000_0001);
		write_reg(REG_MIX, 32'h0000_0000);
		stage_sample(sample_t'(-20000));
		stage_sample(sample_t'(32767));
		wait_drained();

		// delay at its top
		write_reg(REG_DELAY, 32'hffff_ffff);
		write_reg(REG_MIX, 32'h0001_4000);
		stage_sample(sample_t'(-32768));
		stage_sample(sample_t'(32767));
		wait_drained();

		// echo off, then back on to see the lines kept
		write_reg(REG_ENABLE, 32'hffff_fffe);
		stage_sample(sample_t'(32767));
		stage_sample(sample_t'(-32768));
		stage_sample(sample_t'(777));
		wait_drained();
		write_reg(REG_ENABLE, 32'h0000_0001);
		write_reg(REG_DELAY, 32'h0000_0002);
		stage_sample(sample_t'(100));
		stage_sample(sample_t'(-100));
		stage_sample('0);
		wait_drained();

		// random phases
		total = 0;
		while (total < SAMPLE_GOAL) begin
			n = $urandom_range(30, 80);
			random_setup();
			queue_samples(n);
			total += n;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("stereo_crossfeed_delay_top verification clean");
		else
			$display("stereo_crossfeed_delay_top verification failed");
		$finish;
	end

	// input driver, prediction on each accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				pair_q = {pair_q, echo_step(sample_in)};
			if (!in_valid || !in_stall) begin
				if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
					in_valid  <= 1'b1;
					sample_in <= sample_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and random stall
	always @(posedge clk) begin
		stereo_pair_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pair_q.size() == 0) begin
					$error("stereo transaction with no sample pending: left_out %0d right_out %0d",
						left_out, right_out);
					fail_cnt++;
				end else begin
					want = pair_q.pop_front();
					if (left_out !== want.left) begin
						$error("left_out expected %0d got %0d", want.left, left_out);
						fail_cnt++;
					end
					if (right_out !== want.right) begin
						$error("right_out expected %0d got %0d", want.right, right_out);
						fail_cnt++;
					end
				end
			end
			out_stall <= !calm && ($urandom_range(99) < 20);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("stereo_crossfeed_delay_top verification failed");
			$finish;
		end
	end

endmodule
